[rtl/fisr_pkg.sv]
`default_nettype none

package fisr_pkg;

	// Constants of the seed and of the Newton step, as single-precision bits.
	localparam logic [31:0] SEED_MAGIC  = 32'h5f375a86;
	localparam logic [31:0] F_HALF      = 32'h3f000000;
	localparam logic [31:0] F_THREE_HLF = 32'h3fc00000;
	localparam logic [31:0] F_DEF_NAN   = 32'hffc00000;
	localparam logic [31:0] F_QUIET     = 32'h00400000;

	// Multiplier state between the product stage and the rounding stage.
	typedef struct packed {
		logic               special;
		logic [31:0]        spec_val;
		logic               sign;
		logic signed [10:0] be_base;
		logic [47:0]        prod;
	} mul_mid_t;

	// Adder state between the alignment stage and the sum stage.
	typedef struct packed {
		logic        special;
		logic [31:0] spec_val;
		logic        sign_big;
		logic        sub_op;
		logic [7:0]  e_big;
		logic [26:0] m_big;
		logic [26:0] m_small;
	} add_mid_t;

	// Leading zero count over 48 bits; a zero input gives 48.
	function automatic logic [5:0] lzc48(input logic [47:0] v);
		logic [5:0] n;
		logic       found;
		n     = 6'd0;
		found = 1'b0;
		for (int i = 47; i >= 0; i--) begin
			if (!found) begin
				if (v[i]) begin
					found = 1'b1;
				end else begin
					n = n + 6'd1;
				end
			end
		end
		return n;
	endfunction

	function automatic logic is_nan(input logic [31:0] x);
		return (x[30:23] == 8'hff) && (x[22:0] != 23'd0);
	endfunction

	function automatic logic is_inf(input logic [31:0] x);
		return (x[30:23] == 8'hff) && (x[22:0] == 23'd0);
	endfunction

	function automatic logic is_zero(input logic [31:0] x);
		return x[30:0] == 31'd0;
	endfunction

	// Multiply, first half: special operands and the raw mantissa product.
	function automatic mul_mid_t fmul_a(input logic [31:0] a, input logic [31:0] b);
		mul_mid_t   m;
		logic [7:0] ea;
		logic [7:0] eb;
		m.sign     = a[31] ^ b[31];
		m.special  = 1'b1;
		m.spec_val = {m.sign, 31'd0};
		ea         = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
		eb         = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
		m.be_base  = $signed({3'b0, ea}) + $signed({3'b0, eb}) - 11'sd126;
		m.prod     = {24'd0, a[30:23] != 8'd0, a[22:0]} * {24'd0, b[30:23] != 8'd0, b[22:0]};
		if (is_nan(a)) begin
			m.spec_val = a | F_QUIET;
		end else if (is_nan(b)) begin
			m.spec_val = b | F_QUIET;
		end else if ((is_inf(a) && is_zero(b)) || (is_inf(b) && is_zero(a))) begin
			m.spec_val = F_DEF_NAN;
		end else if (is_inf(a) || is_inf(b)) begin
			m.spec_val = {m.sign, 8'hff, 23'd0};
		end else if (is_zero(a) || is_zero(b)) begin
			m.spec_val = {m.sign, 31'd0};
		end else begin
			m.special = 1'b0;
		end
		return m;
	endfunction

	// Multiply, second half: normalize, denormalize if tiny, round to nearest even.
	function automatic logic [31:0] fmul_b(input mul_mid_t m);
		logic [5:0]         lz;
		logic [47:0]        pn;
		logic signed [10:0] be;
		logic [6:0]         sh;
		logic [95:0]        wide;
		logic [23:0]        mant;
		logic               g;
		logic               s;
		logic [7:0]         field;
		logic [30:0]        mag;
		lz = lzc48(m.prod);
		pn = m.prod << lz;
		be = m.be_base - $signed({5'b0, lz});
		if (be >= 11'sd1) begin
			mant  = pn[47:24];
			g     = pn[23];
			s     = |pn[22:0];
			field = be[7:0];
		end else begin
			if (be < -11'sd58) begin
				sh = 7'd60;
			end else begin
				sh = 7'(11'sd1 - be);
			end
			wide  = {pn, 48'd0} >> sh;
			mant  = wide[95:72];
			g     = wide[71];
			s     = |wide[70:0];
			field = 8'd0;
		end
		mag = {field, mant[22:0]} + {30'd0, g & (s | mant[0])};
		if (m.special) begin
			return m.spec_val;
		end else if (be >= 11'sd255) begin
			return {m.sign, 8'hff, 23'd0};
		end
		return {m.sign, mag};
	endfunction

	// Subtract a - b, first half: special operands, order by magnitude, align.
	function automatic add_mid_t fsub_a(input logic [31:0] a, input logic [31:0] b);
		add_mid_t    r;
		logic        bs;
		logic [31:0] big;
		logic [31:0] sml;
		logic        sign_sml;
		logic [7:0]  es;
		logic [7:0]  d;
		logic [4:0]  dc;
		logic [53:0] wide;
		bs = ~b[31];
		if (a[30:0] >= b[30:0]) begin
			big        = a;
			sml        = b;
			r.sign_big = a[31];
			sign_sml   = bs;
		end else begin
			big        = b;
			sml        = a;
			r.sign_big = bs;
			sign_sml   = a[31];
		end
		r.sub_op  = r.sign_big ^ sign_sml;
		r.e_big   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
		es        = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
		d         = r.e_big - es;
		dc        = (d > 8'd31) ? 5'd31 : d[4:0];
		r.m_big   = {big[30:23] != 8'd0, big[22:0], 3'd0};
		wide      = {sml[30:23] != 8'd0, sml[22:0], 3'd0, 27'd0} >> dc;
		r.m_small = wide[53:27] | {26'd0, |wide[26:0]};
		r.special = 1'b1;
		if (is_nan(a)) begin
			r.spec_val = a | F_QUIET;
		end else if (is_nan(b)) begin
			r.spec_val = b | F_QUIET;
		end else if (is_inf(a) && is_inf(b) && (a[31] != bs)) begin
			r.spec_val = F_DEF_NAN;
		end else if (is_inf(a)) begin
			r.spec_val = a;
		end else if (is_inf(b)) begin
			r.spec_val = {bs, 8'hff, 23'd0};
		end else begin
			r.special  = 1'b0;
			r.spec_val = 32'd0;
		end
		return r;
	endfunction

	// Add, second half: sum or difference, normalize, round to nearest even.
	function automatic logic [31:0] fadd_b(input add_mid_t r);
		logic [27:0] sum;
		logic [26:0] v;
		logic [8:0]  e;
		logic [5:0]  lz;
		logic [5:0]  sh;
		logic [7:0]  field;
		logic        g;
		logic        s;
		logic [30:0] mag;
		if (r.sub_op) begin
			sum = {1'b0, r.m_big} - {1'b0, r.m_small};
		end else begin
			sum = {1'b0, r.m_big} + {1'b0, r.m_small};
		end
		lz = lzc48({sum[26:0], 21'h1fffff});
		if (sum[27]) begin
			v     = {sum[27:2], sum[1] | sum[0]};
			e     = {1'b0, r.e_big} + 9'd1;
			field = e[7:0];
		end else begin
			if ({3'd0, lz} > r.e_big - 8'd1) begin
				sh = 6'(r.e_big - 8'd1);
			end else begin
				sh = lz;
			end
			v     = sum[26:0] << sh;
			e     = {1'b0, r.e_big} - {3'd0, sh};
			field = v[26] ? e[7:0] : 8'd0;
		end
		g   = v[2];
		s   = |v[1:0];
		mag = {field, v[25:3]} + {30'd0, g & (s | v[3])};
		if (r.special) begin
			return r.spec_val;
		end else if (sum == 28'd0) begin
			return {r.sign_big & ~r.sub_op, 31'd0};
		end else if (e >= 9'd255) begin
			return {r.sign_big, 8'hff, 23'd0};
		end
		return {r.sign_big, mag};
	endfunction

endpackage

`default_nettype wire

[rtl/fast_inverse_square_root.sv]
// Fast inverse square root with one Newton step, on raw single-precision bits.
// Input channel: value_bits with in_valid / in_ready. Output channel:
// result_bits with out_valid / out_ready. A transfer happens on a rising
// clock edge where valid and ready are both high.
// The seed is 0x5f375a86 minus the arithmetic right shift of the input word;
// then half = a*0.5, t = half*y, t = t*y, t = 1.5 - t, result = y*t, each
// rounded to single precision, round to nearest even, subnormals kept.
// There are ten register stages: each of the four multiplies takes two
// (mantissa product, then normalize and round) and the subtract takes two
// (align, then sum and round). Throughput is one item per cycle while the
// receiver takes results; every stage holds one item.
// When the receiver stalls with a result waiting, full stages hold and in_ready
// falls once every stage is full; bubbles in the pipeline still move forward and
// in_ready stays high as long as any stage is empty or the last one is being taken.
// Asynchronous reset clears all valid bits; no result is shown after reset
// until an item has gone through.
`default_nettype none

module fast_inverse_square_root import fisr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] value_bits,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      result_bits
);

	logic [10:1] vld_pipe_q;
	logic        adv;
	logic [10:1] mov;

	mul_mid_t    m_s1, m_s3, m_s5, m_s9;
	add_mid_t    a_s7;
	logic [31:0] y_s1, y_s2, y_s3, y_s4, y_s5, y_s6, y_s7, y_s8;
	logic [31:0] half_s2, t1_s4, t2_s6, t3_s8, r_s10;

	// A stage loads when it is empty or the stage ahead of it can take its item.
	assign adv = !vld_pipe_q[10] || out_ready;
	always_comb begin
		mov[10] = adv;
		for (int i = 9; i >= 1; i--) begin
			mov[i] = mov[i + 1] || !vld_pipe_q[i + 1];
		end
	end
	assign in_ready = mov[1] || !vld_pipe_q[1];

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_pipe_q <= '0;
		end else begin
			if (in_ready) begin
				vld_pipe_q[1] <= in_valid;
			end
			for (int i = 2; i <= 10; i++) begin
				if (mov[i] || !vld_pipe_q[i]) begin
					vld_pipe_q[i] <= vld_pipe_q[i - 1];
				end
			end
		end
	end

	// Datapath stages; each loads under the same condition as its valid bit.
	always_ff @(posedge clk) begin
		if (in_ready) begin
			m_s1 <= fmul_a(value_bits, F_HALF);
			y_s1 <= SEED_MAGIC - {value_bits[31], value_bits[31:1]};
		end
		if (mov[2] || !vld_pipe_q[2]) begin
			half_s2 <= fmul_b(m_s1);
			y_s2    <= y_s1;
		end
		if (mov[3] || !vld_pipe_q[3]) begin
			m_s3 <= fmul_a(half_s2, y_s2);
			y_s3 <= y_s2;
		end
		if (mov[4] || !vld_pipe_q[4]) begin
			t1_s4 <= fmul_b(m_s3);
			y_s4  <= y_s3;
		end
		if (mov[5] || !vld_pipe_q[5]) begin
			m_s5 <= fmul_a(t1_s4, y_s4);
			y_s5 <= y_s4;
		end
		if (mov[6] || !vld_pipe_q[6]) begin
			t2_s6 <= fmul_b(m_s5);
			y_s6  <= y_s5;
		end
		if (mov[7] || !vld_pipe_q[7]) begin
			a_s7 <= fsub_a(F_THREE_HLF, t2_s6);
			y_s7 <= y_s6;
		end
		if (mov[8] || !vld_pipe_q[8]) begin
			t3_s8 <= fadd_b(a_s7);
			y_s8  <= y_s7;
		end
		if (mov[9] || !vld_pipe_q[9]) begin
			m_s9 <= fmul_a(y_s8, t3_s8);
		end
		if (mov[10] || !vld_pipe_q[10]) begin
			r_s10 <= fmul_b(m_s9);
		end
	end

	assign out_valid   = vld_pipe_q[10];
	assign result_bits = r_s10;

endmodule

`default_nettype wire

[test/fast_inverse_square_root_tb.sv]
`timescale 1ns / 1ps

module fast_inverse_square_root_tb import fisr_pkg::*; ();

	localparam int CYCLE_LIMIT = 400000;

	// Bit-level single-precision model of the seed and one Newton refinement.
	class rsqrt_scoreboard;
		logic [31:0] expected_results[$];
		int          mismatches = 0;

		// Split a single into an integer significand and the weight of its lsb.
		function void unpack(input bit [31:0] x, output bit [23:0] m, output int e);
			if (x[30:23] == 8'd0) begin
				m = {1'b0, x[22:0]};
				e = -149;
			end else begin
				m = {1'b1, x[22:0]};
				e = int'(x[30:23]) - 150;
			end
		endfunction

		// Round mag * 2^ex to single, nearest even, with subnormals and overflow.
		function bit [31:0] round_single(input bit sgn, input int ex, input bit [127:0] mag);
			int         p;
			int         lsb;
			int         sh;
			bit [127:0] mant;
			bit [127:0] mask;
			bit         g;
			bit         s;
			longint     r;
			p = 0;
			for (int i = 0; i < 128; i++) begin
				if (mag[i]) p = i;
			end
			lsb = p + ex - 23;
			if (lsb < -149) lsb = -149;
			sh = lsb - ex;
			if (sh > 0) begin
				mant = (sh >= 128) ? 128'd0 : (mag >> sh);
				g    = (sh - 1 < 128) ? mag[sh - 1] : 1'b0;
				mask = (sh - 1 >= 128) ? {128{1'b1}} : ((128'd1 << (sh - 1)) - 128'd1);
				s    = (mag & mask) != 128'd0;
			end else begin
				mant = mag << (-sh);
				g    = 1'b0;
				s    = 1'b0;
			end
			mant = mant + {127'd0, g & (s | mant[0])};
			r = (longint'(lsb + 149) <<< 23) + longint'(mant[63:0]);
			if (r >= 64'sh7f800000) return {sgn, 31'h7f800000};
			return {sgn, r[30:0]};
		endfunction

		function bit is_nan_val(input bit [31:0] x);
			return (x[30:23] == 8'hff) && (x[22:0] != 23'd0);
		endfunction

		function bit is_inf_val(input bit [31:0] x);
			return x[30:0] == 31'h7f800000;
		endfunction

		// Single-precision product.
		function bit [31:0] mul_single(input bit [31:0] a, input bit [31:0] b);
			bit        sgn;
			bit [23:0] ma;
			bit [23:0] mb;
			int        ea;
			int        eb;
			sgn = a[31] ^ b[31];
			if (is_nan_val(a)) return a | F_QUIET;
			if (is_nan_val(b)) return b | F_QUIET;
			if ((is_inf_val(a) && b[30:0] == 31'd0) || (is_inf_val(b) && a[30:0] == 31'd0))
				return F_DEF_NAN;
			if (is_inf_val(a) || is_inf_val(b)) return {sgn, 31'h7f800000};
			if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return {sgn, 31'd0};
			unpack(a, ma, ea);
			unpack(b, mb, eb);
			return round_single(sgn, ea + eb, {80'd0, 48'(ma) * 48'(mb)});
		endfunction

		// Single-precision difference a - b.
		function bit [31:0] sub_single(input bit [31:0] a, input bit [31:0] b);
			bit [31:0]  bn;
			bit [31:0]  big;
			bit [31:0]  sml;
			bit [23:0]  mbig;
			bit [23:0]  msml;
			int         ebig;
			int         esml;
			int         d;
			bit [127:0] wide;
			bit [127:0] part;
			bit         sticky;
			bit [127:0] sum;
			bn = b ^ 32'h80000000;
			if (is_nan_val(a)) return a | F_QUIET;
			if (is_nan_val(b)) return b | F_QUIET;
			if (is_inf_val(a) && is_inf_val(bn) && (a[31] != bn[31])) return F_DEF_NAN;
			if (is_inf_val(a)) return a;
			if (is_inf_val(bn)) return bn;
			if (a[30:0] == 31'd0 && bn[30:0] == 31'd0) return {a[31] & bn[31], 31'd0};
			if (a[30:0] >= bn[30:0]) begin
				big = a;
				sml = bn;
			end else begin
				big = bn;
				sml = a;
			end
			unpack(big, mbig, ebig);
			unpack(sml, msml, esml);
			d    = ebig - esml;
			wide = 128'(msml) << 64;
			if (d > 127) begin
				part   = 128'd0;
				sticky = msml != 24'd0;
			end else begin
				part   = wide >> d;
				sticky = (wide & ((128'd1 << d) - 128'd1)) != 128'd0;
			end
			part = part | {127'd0, sticky};
			if (big[31] ^ sml[31]) begin
				sum = (128'(mbig) << 64) - part;
			end else begin
				sum = (128'(mbig) << 64) + part;
			end
			if (sum == 128'd0) return 32'd0;
			return round_single(big[31], ebig - 64, sum);
		endfunction

		// Seed from the magic constant, then y * (1.5 - (half * y) * y).
		function bit [31:0] rsqrt_estimate(input bit [31:0] v);
			bit [31:0] half;
			bit [31:0] y;
			bit [31:0] t;
			half = mul_single(v, F_HALF);
			y    = SEED_MAGIC - {v[31], v[31:1]};
			t    = mul_single(half, y);
			t    = mul_single(t, y);
			t    = sub_single(F_THREE_HLF, t);
			return mul_single(y, t);
		endfunction

		function void note_operand(input logic [31:0] v);
			expected_results.push_back(rsqrt_estimate(v));
		endfunction

		function void check_result(input logic [31:0] actual);
			logic [31:0] want;
			if (expected_results.size() == 0) begin
				$error("result_bits: expected none, actual %08h", actual);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				if (actual !== want) begin
					$error("result_bits: expected %08h, actual %08h", want, actual);
					mismatches++;
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] value_bits;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] result_bits;

	rsqrt_scoreboard scoreboard = new();
	int              send_idle_pct = 0;
	int              recv_stall_pct = 0;
	int              hold_left = 0;
	int              cycle_count = 0;

	fast_inverse_square_root dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.value_bits  (value_bits),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_bits (result_bits)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watch both channels and hand every transfer to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) scoreboard.note_operand(value_bits);
		if (arst_n && out_valid && out_ready) scoreboard.check_result(result_bits);
	end

	// Guard against a hung pipeline.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Receiver: random stalls, plus a long hold-off when one is requested.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left = hold_left - 1;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Offer one operand, with random idle cycles ahead of it.
	task automatic send_operand(input logic [31:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		value_bits <= v;
		do @(posedge clk); while (!in_ready);
	endtask

	// Random operand biased toward the interesting exponents.
	function automatic logic [31:0] random_operand();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(7))
			0: v[30:23] = 8'd0;
			1: v[30:23] = 8'hff;
			2: v[30:23] = 8'd127 + 8'($urandom_range(8)) - 8'd4;
			3: v[30:23] = 8'($urandom_range(3)) + (($urandom_range(1) == 1) ? 8'd250 : 8'd1);
			default: ;
		endcase
		if ($urandom_range(3) != 0) v[31] = 1'b0;
		return v;
	endfunction

	task automatic random_phase(input int count, input int idle_pct, input int stall_pct,
			input bit pressure);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		if (pressure) hold_left = 300;
		for (int i = 0; i < count; i++) begin
			if (pressure && i == count / 2) begin
				// Let the last transfer reach the scoreboard before draining.
				in_valid <= 1'b0;
				@(posedge clk);
				wait (scoreboard.expected_results.size() == 0);
				@(posedge clk);
			end
			send_operand(random_operand());
		end
	endtask

	logic [31:0] directed[] = '{
		32'h00000000, 32'h80000000, 32'h7f800000, 32'hff800000, 32'h7fc00000,
		32'h7f800001, 32'hffffffff, 32'h00000001, 32'h007fffff, 32'h00800000,
		32'h7f7fffff, 32'h3f800000, 32'h40800000, 32'hbf800000, 32'h3e800000,
		32'h5f000000, 32'h7e800000, 32'h80000001, 32'h3fc00000, 32'h00400000
	};

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		value_bits = 32'd0;
		out_ready  = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Corner operands with no idling on either side.
		foreach (directed[i]) send_operand(directed[i]);

		random_phase(210, 0, 0, 1'b0);
		random_phase(210, 79, 0, 1'b1);
		random_phase(210, 0, 79, 1'b0);
		random_phase(210, 34, 34, 1'b0);
		in_valid <= 1'b0;

		// The last transfer is noted at its own edge, so let that edge pass before waiting.
		@(posedge clk);
		wait (scoreboard.expected_results.size() == 0);
		repeat (20) @(posedge clk);
		if (scoreboard.mismatches == 0 && scoreboard.expected_results.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

[files.f]
rtl/fisr_pkg.sv
rtl/fast_inverse_square_root.sv
test/fast_inverse_square_root_tb.sv
